/* src/rsm_pkg.sv */
`default_nettype none
package rsm_pkg;

  localparam int SAMPLE_W = 16;
  localparam int COUNT_W  = 7;
  localparam int SUM_W    = 22;
  localparam int SUMSQ_W  = 37;
  localparam int MEAN_W   = 24;
  localparam int STDDEV_W = 24;

  // variance scaled by 2^16 stays below 2^47 for any sample count
  localparam int VAR_W   = 48;
  localparam int ROOT_W  = VAR_W / 2;
  localparam int VAR_FRAC_W  = 16;
  localparam int MEAN_FRAC_W = 8;

  localparam logic KIND_ADD   = 1'b0;
  localparam logic KIND_CLEAR = 1'b1;

  localparam logic signed [SAMPLE_W-1:0] MIN_EMPTY = 16'sh7fff;
  localparam logic signed [SAMPLE_W-1:0] MAX_EMPTY = 16'sh8000;

endpackage
`default_nettype wire

/* src/rsm_ifs.sv */
`default_nettype none
interface rsm_in_if;
  import rsm_pkg::*;
  logic                       valid;
  logic                       ready;
  logic                       kind;
  logic signed [SAMPLE_W-1:0] sample;

  modport source (output valid, output kind, output sample, input ready);
  modport sink   (input valid, input kind, input sample, output ready);
endinterface

interface rsm_out_if;
  import rsm_pkg::*;
  logic                       valid;
  logic                       ready;
  logic        [COUNT_W-1:0]  sample_count;
  logic signed [SUM_W-1:0]    running_sum;
  logic        [SUMSQ_W-1:0]  running_sum_squares;
  logic signed [MEAN_W-1:0]   mean_q8;
  logic        [STDDEV_W-1:0] stddev_q8;
  logic signed [SAMPLE_W-1:0] smallest;
  logic signed [SAMPLE_W-1:0] largest;
  logic signed [SAMPLE_W-1:0] middle_value;
  logic                       rejected;

  modport source (output valid, output sample_count, output running_sum,
                  output running_sum_squares, output mean_q8, output stddev_q8,
                  output smallest, output largest, output middle_value,
                  output rejected, input ready);
  modport sink   (input valid, input sample_count, input running_sum,
                  input running_sum_squares, input mean_q8, input stddev_q8,
                  input smallest, input largest, input middle_value,
                  input rejected, output ready);
endinterface
`default_nettype wire

/* src/running_stats_with_median_core.sv */
`default_nettype none
// Per request: a clear goes straight to the empty result. A dropped add, and an
// add after its sorted insert (each larger entry shifted up in turn), run the
// n*S2 shift-add, variance divide, square root and mean divide; a lone sample
// skips the variance divide and square root. One request at a time; in_ready is
// high only while idle, so a new request is taken only once the last result has
// been accepted. Synchronous active-low reset empties the statistics.
module running_stats_with_median_core #(
  parameter int MAX_SAMPLES = 64
) (
  input  wire         clk,
  input  wire         rst_n,
  rsm_in_if.sink      in_chan,
  rsm_out_if.source   out_chan
);
  import rsm_pkg::*;

  localparam int AW  = $clog2(MAX_SAMPLES);
  localparam int CW  = $clog2(MAX_SAMPLES + 1);
  localparam int SW  = SAMPLE_W + AW;
  localparam int QW  = 2 * SAMPLE_W - 1 + AW;
  localparam int DW  = CW + QW;
  localparam int EW  = (DW > 2 * SW) ? DW : 2 * SW;
  localparam int NW  = EW + VAR_FRAC_W;
  localparam int MW  = 2 * CW;
  localparam int IW  = $clog2(NW + 1);
  localparam int RW  = ROOT_W + 2;
  localparam int MQW = SW + MEAN_FRAC_W;
  localparam int MNW = MQW + 1;

  typedef enum logic [3:0] {
    S_IDLE, S_INS_RD, S_INS_CMP, S_UPD, S_MED_RD, S_MED_CAP,
    S_MUL, S_VAR_DIV, S_SQRT, S_MEAN_DIV, S_OUT
  } state_t;

  state_t                      state_r;
  logic        [CW-1:0]        count_r;
  logic signed [SW-1:0]        sum_r;
  logic        [QW-1:0]        sq_r;
  logic signed [SAMPLE_W-1:0]  min_r, max_r, samp_r, med_r;
  logic                        rej_r, out_valid_r;
  logic        [CW-1:0]        pos_r;
  logic        [SW-1:0]        mag_r;
  logic        [MW-1:0]        m_r;
  logic        [2*SW-1:0]      sqm_r;
  logic        [EW-1:0]        mul_acc_r, mul_a_r;
  logic        [CW-1:0]        mul_b_r;
  logic        [IW-1:0]        iter_r;
  logic        [MW-1:0]        div_rem_r, div_den_r;
  logic        [NW-1:0]        div_quo_r;
  logic        [VAR_W-1:0]     sq_v_r;
  logic        [RW-1:0]        sq_rem_r;
  logic        [ROOT_W-1:0]    sq_root_r;
  logic        [ROOT_W-1:0]    std_r;
  logic signed [MNW-1:0]       mean_r;

  // sorted store
  logic signed [SAMPLE_W-1:0]  mem [MAX_SAMPLES];
  logic signed [SAMPLE_W-1:0]  mem_rd_r;
  logic        [AW-1:0]        rd_addr, wr_addr;
  logic                        mem_we;
  logic signed [SAMPLE_W-1:0]  wr_data;

  always_comb begin
    rd_addr = AW'(count_r >> 1);
    if (state_r == S_INS_RD) begin
      rd_addr = AW'(pos_r - 1'b1);
    end
    wr_addr = AW'(pos_r);
    mem_we  = 1'b0;
    wr_data = samp_r;
    if (state_r == S_INS_RD && pos_r == '0) begin
      mem_we = 1'b1;
    end
    if (state_r == S_INS_CMP) begin
      mem_we = 1'b1;
      if (mem_rd_r > samp_r) begin
        wr_data = mem_rd_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= wr_data;
    end
    mem_rd_r <= mem[rd_addr];
  end

  // shared restoring divider step
  logic [MW:0]   div_trial;
  logic          div_ge;
  logic [MW-1:0] div_rem_nxt;
  logic [NW-1:0] div_quo_nxt;
  assign div_trial   = {div_rem_r, div_quo_r[NW-1]};
  assign div_ge      = div_trial >= {1'b0, div_den_r};
  assign div_rem_nxt = div_ge ? MW'(div_trial - {1'b0, div_den_r}) : MW'(div_trial);
  assign div_quo_nxt = {div_quo_r[NW-2:0], div_ge};

  // square root step, two bits of the radicand per cycle
  logic [RW+1:0]     sq_shift, sq_trial;
  logic              sq_ge;
  assign sq_shift = {sq_rem_r, sq_v_r[VAR_W-1 -: 2]};
  assign sq_trial = (RW + 2)'({sq_root_r, 2'b01});
  assign sq_ge    = sq_shift >= sq_trial;

  logic signed [2*SAMPLE_W-1:0] samp_sq;
  assign samp_sq = (2 * SAMPLE_W)'(samp_r) * (2 * SAMPLE_W)'(samp_r);

  logic [EW-1:0]  var_num;
  assign var_num = (mul_acc_r > EW'(sqm_r)) ? mul_acc_r - EW'(sqm_r) : '0;

  logic [NW-1:0]  mean_dividend;
  assign mean_dividend = NW'({mag_r, {MEAN_FRAC_W{1'b0}}}) << (NW - MQW);

  logic signed [MNW-1:0] mean_pos, mean_neg;
  assign mean_pos = $signed(MNW'(div_quo_r[MQW-1:0]));
  assign mean_neg = -mean_pos - MNW'(div_rem_r != '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      sum_r       <= '0;
      sq_r        <= '0;
      min_r       <= MIN_EMPTY;
      max_r       <= MAX_EMPTY;
      out_valid_r <= 1'b0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (in_chan.valid) begin
            samp_r <= in_chan.sample;
            pos_r  <= count_r;
            if (in_chan.kind == KIND_CLEAR) begin
              rej_r   <= 1'b0;
              count_r <= '0;
              sum_r   <= '0;
              sq_r    <= '0;
              min_r   <= MIN_EMPTY;
              max_r   <= MAX_EMPTY;
              state_r <= S_MED_RD;
            end else if (count_r == CW'(MAX_SAMPLES)) begin
              rej_r   <= 1'b1;
              state_r <= S_MED_RD;
            end else begin
              rej_r   <= 1'b0;
              state_r <= S_INS_RD;
            end
          end
        end
        S_INS_RD: begin
          state_r <= (pos_r == '0) ? S_UPD : S_INS_CMP;
        end
        S_INS_CMP: begin
          // shift the larger entry up and keep walking down
          if (mem_rd_r > samp_r) begin
            pos_r   <= pos_r - 1'b1;
            state_r <= S_INS_RD;
          end else begin
            state_r <= S_UPD;
          end
        end
        S_UPD: begin
          count_r <= count_r + 1'b1;
          sum_r   <= sum_r + SW'(samp_r);
          sq_r    <= sq_r + QW'($unsigned(samp_sq));
          if (samp_r < min_r) begin
            min_r <= samp_r;
          end
          if (samp_r > max_r) begin
            max_r <= samp_r;
          end
          state_r <= S_MED_RD;
        end
        S_MED_RD: begin
          mag_r <= sum_r[SW-1] ? $unsigned(-sum_r) : $unsigned(sum_r);
          m_r   <= MW'(count_r) * MW'(count_r - 1'b1);
          if (count_r == '0) begin
            med_r       <= '0;
            mean_r      <= '0;
            std_r       <= '0;
            out_valid_r <= 1'b1;
            state_r     <= S_OUT;
          end else begin
            state_r <= S_MED_CAP;
          end
        end
        S_MED_CAP: begin
          med_r     <= mem_rd_r;
          sqm_r     <= (2 * SW)'(mag_r) * (2 * SW)'(mag_r);
          mul_acc_r <= '0;
          mul_a_r   <= EW'(sq_r);
          mul_b_r   <= count_r;
          iter_r    <= IW'(CW);
          state_r   <= S_MUL;
        end
        S_MUL: begin
          if (iter_r == '0) begin
            div_rem_r <= '0;
            if (count_r <= CW'(1)) begin
              std_r     <= '0;
              div_den_r <= MW'(count_r);
              div_quo_r <= mean_dividend;
              iter_r    <= IW'(MQW);
              state_r   <= S_MEAN_DIV;
            end else begin
              div_den_r <= m_r;
              div_quo_r <= {var_num, {VAR_FRAC_W{1'b0}}};
              iter_r    <= IW'(NW);
              state_r   <= S_VAR_DIV;
            end
          end else begin
            if (mul_b_r[0]) begin
              mul_acc_r <= mul_acc_r + mul_a_r;
            end
            mul_a_r <= mul_a_r << 1;
            mul_b_r <= mul_b_r >> 1;
            iter_r  <= iter_r - 1'b1;
          end
        end
        S_VAR_DIV: begin
          if (iter_r == '0) begin
            sq_v_r    <= div_quo_r[VAR_W-1:0];
            sq_rem_r  <= '0;
            sq_root_r <= '0;
            iter_r    <= IW'(ROOT_W);
            state_r   <= S_SQRT;
          end else begin
            div_rem_r <= div_rem_nxt;
            div_quo_r <= div_quo_nxt;
            iter_r    <= iter_r - 1'b1;
          end
        end
        S_SQRT: begin
          if (iter_r == '0) begin
            std_r     <= sq_root_r;
            div_rem_r <= '0;
            div_den_r <= MW'(count_r);
            div_quo_r <= mean_dividend;
            iter_r    <= IW'(MQW);
            state_r   <= S_MEAN_DIV;
          end else begin
            sq_rem_r  <= sq_ge ? RW'(sq_shift - sq_trial) : RW'(sq_shift);
            sq_root_r <= {sq_root_r[ROOT_W-2:0], sq_ge};
            sq_v_r    <= sq_v_r << 2;
            iter_r    <= iter_r - 1'b1;
          end
        end
        S_MEAN_DIV: begin
          if (iter_r == '0) begin
            // floor toward minus infinity for a negative sum
            mean_r      <= sum_r[SW-1] ? mean_neg : mean_pos;
            out_valid_r <= 1'b1;
            state_r     <= S_OUT;
          end else begin
            div_rem_r <= div_rem_nxt;
            div_quo_r <= div_quo_nxt;
            iter_r    <= iter_r - 1'b1;
          end
        end
        S_OUT: begin
          if (out_chan.ready) begin
            out_valid_r <= 1'b0;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_chan.ready                = (state_r == S_IDLE);
  assign out_chan.valid               = out_valid_r;
  assign out_chan.sample_count        = COUNT_W'(count_r);
  assign out_chan.running_sum         = SUM_W'(sum_r);
  assign out_chan.running_sum_squares = SUMSQ_W'(sq_r);
  assign out_chan.mean_q8             = MEAN_W'(mean_r);
  assign out_chan.stddev_q8           = STDDEV_W'(std_r);
  assign out_chan.smallest            = min_r;
  assign out_chan.largest             = max_r;
  assign out_chan.middle_value        = med_r;
  assign out_chan.rejected            = rej_r;

endmodule
`default_nettype wire

/* src/rsm_checker.sv */
`default_nettype none
module rsm_checker #(
  parameter int MAX_SAMPLES = 64
) (
  input wire                                clk,
  input wire                                rst_n,
  input wire                                in_valid,
  input wire                                in_ready,
  input wire                                out_valid,
  input wire                                out_ready,
  input wire        [rsm_pkg::COUNT_W-1:0]  out_sample_count,
  input wire signed [rsm_pkg::MEAN_W-1:0]   out_mean_q8,
  input wire        [rsm_pkg::STDDEV_W-1:0] out_stddev_q8,
  input wire signed [rsm_pkg::SAMPLE_W-1:0] out_smallest,
  input wire signed [rsm_pkg::SAMPLE_W-1:0] out_largest,
  input wire signed [rsm_pkg::SAMPLE_W-1:0] out_middle_value,
  input wire                                out_rejected
);
  import rsm_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("new request taken while a result is pending");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("ready stayed high after a request");

  a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_sample_count == '0 && MAX_SAMPLES < 128 |->
      out_smallest == MIN_EMPTY && out_largest == MAX_EMPTY &&
      out_mean_q8 == '0 && out_stddev_q8 == '0 && out_middle_value == '0)
    else $error("empty statistics not at their reset values");

  a_reject_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_rejected |-> out_sample_count == COUNT_W'(MAX_SAMPLES))
    else $error("sample dropped while store not full");

endmodule

bind running_stats_with_median_core rsm_checker #(.MAX_SAMPLES(MAX_SAMPLES)) u_rsm_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_chan.valid),
  .in_ready         (in_chan.ready),
  .out_valid        (out_chan.valid),
  .out_ready        (out_chan.ready),
  .out_sample_count (out_chan.sample_count),
  .out_mean_q8      (out_chan.mean_q8),
  .out_stddev_q8    (out_chan.stddev_q8),
  .out_smallest     (out_chan.smallest),
  .out_largest      (out_chan.largest),
  .out_middle_value (out_chan.middle_value),
  .out_rejected     (out_chan.rejected)
);
`default_nettype wire

/* tb/sv/tb.sv */
`timescale 1ns / 1ps
module tb;
  import rsm_pkg::*;

  localparam int DEPTH = 64;

  typedef struct packed {
    logic [COUNT_W-1:0]         cnt;
    logic signed [SUM_W-1:0]    s1;
    logic [SUMSQ_W-1:0]         s2;
    logic signed [MEAN_W-1:0]   mean;
    logic [STDDEV_W-1:0]        sd;
    logic signed [SAMPLE_W-1:0] lo;
    logic signed [SAMPLE_W-1:0] hi;
    logic signed [SAMPLE_W-1:0] med;
    logic                       rej;
  } stats_t;

  typedef struct {
    logic                       kind;
    logic signed [SAMPLE_W-1:0] sample;
    bit                         fixed;
    stats_t                     want;
  } row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  rsm_in_if  in_chan ();
  rsm_out_if out_chan ();

  running_stats_with_median_core #(.MAX_SAMPLES(DEPTH)) uut (
    .clk(clk), .rst_n(rst_n), .in_chan(in_chan), .out_chan(out_chan)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // predictor state
  int          sorted_q[$];
  longint      acc_s1;
  longint      acc_s2;
  int          acc_lo;
  int          acc_hi;
  stats_t      pending_q[$];
  bit          fixed_q[$];
  stats_t      fixed_want_q[$];
  row_t        table_rows[$];

  int errors = 0;
  int results_seen = 0;
  int rejects_seen = 0;
  int clears_sent = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_off = 0;

  function automatic longint int_sqrt(longint unsigned v);
    longint unsigned r = 0;
    longint unsigned b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic void clear_stats();
    sorted_q.delete();
    acc_s1 = 0;
    acc_s2 = 0;
    acc_lo = 32767;
    acc_hi = -32768;
  endfunction

  function automatic stats_t apply_request(logic kind, logic signed [SAMPLE_W-1:0] smp);
    stats_t r;
    int s = smp;
    int pos;
    longint n, num, m, mag, q;
    longint unsigned v, sd;
    r.rej = 1'b0;
    if (kind == KIND_CLEAR) begin
      clear_stats();
    end else if (sorted_q.size() >= DEPTH) begin
      r.rej = 1'b1;
    end else begin
      pos = sorted_q.size();
      while (pos > 0 && sorted_q[pos-1] > s) pos--;
      sorted_q.insert(pos, s);
      acc_s1 += s;
      acc_s2 += longint'(s) * s;
      if (s < acc_lo) acc_lo = s;
      if (s > acc_hi) acc_hi = s;
    end
    n = sorted_q.size();
    r.cnt = COUNT_W'(n);
    r.s1 = SUM_W'(acc_s1);
    r.s2 = SUMSQ_W'(acc_s2);
    r.lo = SAMPLE_W'(acc_lo);
    r.hi = SAMPLE_W'(acc_hi);
    r.mean = '0;
    r.med = '0;
    r.sd = '0;
    if (n > 0) begin
      q = (acc_s1 * 256) / n;
      if (((acc_s1 * 256) % n) != 0 && acc_s1 < 0) q -= 1;
      r.mean = MEAN_W'(q);
      r.med = SAMPLE_W'(sorted_q[n/2]);
    end
    if (n > 1) begin
      mag = (acc_s1 < 0) ? -acc_s1 : acc_s1;
      num = n * acc_s2 - mag * mag;
      if (num < 0) num = 0;
      m = n * (n - 1);
      v = (num / m) * 65536 + ((num % m) * 65536) / m;
      sd = int_sqrt(v);
      r.sd = (sd > 16777215) ? 24'hffffff : sd[23:0];
    end
    return r;
  endfunction

  // receiver
  always @(posedge clk) begin
    stats_t got, want;
    bit fx;
    stats_t fw;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      got = '{out_chan.sample_count, out_chan.running_sum, out_chan.running_sum_squares,
              out_chan.mean_q8, out_chan.stddev_q8, out_chan.smallest, out_chan.largest,
              out_chan.middle_value, out_chan.rejected};
      results_seen++;
      if (got.rej) rejects_seen++;
      if (pending_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %p", got);
      end else begin
        want = pending_q.pop_front();
        fx = fixed_q.pop_front();
        fw = fixed_want_q.pop_front();
        if (fx && fw != want) begin
          errors++;
          if (errors <= 10) $display("table row %p disagrees with predictor %p", fw, want);
        end
        if (got != want) begin
          errors++;
          if (errors <= 10) $display("mismatch: expected %p, got %p", want, got);
        end
      end
    end
  end

  always @(negedge clk) begin
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_chan.ready <= 1'b0;
    end else begin
      out_chan.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic send_request(logic kind, logic signed [SAMPLE_W-1:0] smp, bit fx,
                              stats_t fw);
    stats_t pr;
    while ($urandom_range(99) < send_idle_pct) begin
      in_chan.valid <= 1'b0;
      @(negedge clk);
    end
    in_chan.valid <= 1'b1;
    in_chan.kind <= kind;
    in_chan.sample <= smp;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    pr = apply_request(kind, smp);
    pending_q.insert(pending_q.size(), pr);
    fixed_q.insert(fixed_q.size(), fx);
    fixed_want_q.insert(fixed_want_q.size(), fw);
    if (kind == KIND_CLEAR) clears_sent++;
    @(negedge clk);
  endtask

  function automatic stats_t empty_stats();
    return '{'0, '0, '0, '0, '0, MIN_EMPTY, MAX_EMPTY, '0, 1'b0};
  endfunction

  function automatic stats_t single_stats(logic signed [SAMPLE_W-1:0] s);
    stats_t r;
    r = '{COUNT_W'(1), SUM_W'(s), SUMSQ_W'(longint'(s) * s),
          MEAN_W'(longint'(s) * 256), '0, s, s, s, 1'b0};
    return r;
  endfunction

  function automatic void add_row(logic kind, logic signed [SAMPLE_W-1:0] smp, bit fx,
                                  stats_t want);
    row_t r;
    r.kind = kind;
    r.sample = smp;
    r.fixed = fx;
    r.want = want;
    table_rows.insert(table_rows.size(), r);
  endfunction

  task automatic random_burst(int cnt);
    int fill;
    for (int i = 0; i < cnt; i++) begin
      fill = $urandom_range(99);
      if (fill < 3) begin
        send_request(KIND_CLEAR, SAMPLE_W'($urandom), 1'b0, '0);
      end else begin
        case ($urandom_range(4))
          0: send_request(KIND_ADD, $urandom_range(1) ? 16'sh7fff : 16'sh8000, 1'b0, '0);
          1: send_request(KIND_ADD, SAMPLE_W'($urandom_range(20) - 10), 1'b0, '0);
          default: send_request(KIND_ADD, SAMPLE_W'($urandom), 1'b0, '0);
        endcase
      end
    end
  endtask

  initial begin
    row_t rw;
    int wait_cycles;
    clear_stats();
    in_chan.valid = 1'b0;
    in_chan.kind = KIND_ADD;
    in_chan.sample = '0;
    out_chan.ready = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed table: fixed expectations where obvious
    add_row(KIND_CLEAR, 16'sh1234, 1'b1, empty_stats());
    add_row(KIND_ADD, 16'sh7fff, 1'b1, single_stats(16'sh7fff));
    add_row(KIND_ADD, 16'sh8000, 1'b0, '0);
    add_row(KIND_ADD, 16'sh8000, 1'b0, '0);
    add_row(KIND_ADD, 16'sh0000, 1'b0, '0);
    add_row(KIND_ADD, -16'sd1, 1'b0, '0);
    add_row(KIND_ADD, 16'sh0005, 1'b0, '0);
    add_row(KIND_ADD, 16'sh0005, 1'b0, '0);
    add_row(KIND_CLEAR, 16'shffff, 1'b1, empty_stats());
    add_row(KIND_ADD, 16'sh8000, 1'b1, single_stats(16'sh8000));
    add_row(KIND_ADD, 16'sh8000, 1'b0, '0);
    add_row(KIND_ADD, -16'sd3, 1'b0, '0);
    add_row(KIND_CLEAR, 16'sh0000, 1'b1, empty_stats());
    add_row(KIND_ADD, -16'sd7, 1'b1, single_stats(-16'sd7));
    add_row(KIND_ADD, 16'sd2, 1'b0, '0);
    add_row(KIND_CLEAR, 16'sh5555, 1'b1, empty_stats());
    foreach (table_rows[i]) begin
      rw = table_rows[i];
      send_request(rw.kind, rw.sample, rw.fixed, rw.want);
    end
    // fill with extremes to the top so the last adds are dropped
    for (int i = 0; i < DEPTH + 4; i++)
      send_request(KIND_ADD, i[0] ? 16'sh7fff : 16'sh8000, 1'b0, '0);
    send_request(KIND_CLEAR, 16'sh0, 1'b1, empty_stats());

    send_idle_pct = 0;  recv_stall_pct = 0;  random_burst(320);
    send_idle_pct = 58; recv_stall_pct = 0;  random_burst(320);
    // long receiver hold-off while requests keep coming
    hold_off = 3000;
    send_idle_pct = 0;  recv_stall_pct = 58; random_burst(320);
    send_idle_pct = 12; recv_stall_pct = 12; random_burst(320);
    in_chan.valid <= 1'b0;

    wait_cycles = 0;
    while (pending_q.size() != 0 && wait_cycles < 200000) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (400) @(posedge clk);
    if (pending_q.size() != 0) errors++;
    $display("results checked: %0d, rejected adds: %0d, clears: %0d",
             results_seen, rejects_seen, clears_sent);
    $display("covered empty, extremes, full store, ties and four idle/stall mixes");
    if (errors == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

  initial begin
    #(12 * 2000000);
    $display("tb: errors");
    $finish;
  end
endmodule
